// File: src/sal_pkg.sv
// Package for the shifting array list: capacity, field widths and codes.
// Used by sal_ctrl, sal_datapath and shifting_array_list; depends on nothing.
`default_nettype none

package sal_pkg;

    // Store size and the widths derived from it.
    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the stream payload.
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    // Width that holds both a position and a count for comparisons.
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Stream bus widths: tdata padded to whole bytes.
    localparam int S_DATA_W = ((POS_W + WORD_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((WORD_W + COUNT_W + 7) / 8) * 8;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_GET        = 3'd5,
        OP_SET        = 3'd6
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Output register occupancy tracked by the controller.
    typedef enum logic {
        CTL_FREE = 1'b0,
        CTL_HOLD = 1'b1
    } t_ctl_state;

endpackage

`default_nettype wire

// File: src/shifting_array_list.sv
// Shifting array list: a bounded list of signed words with positional insert.
// The result is registered and appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while the sink takes results; the word cells shift in a single step.
// The result register frees and refills in the same cycle when the sink takes it.
// Reset (synchronous, active low) clears all cells and the fill count at once.
// Top level; depends on sal_pkg, sal_ctrl and sal_datapath.
`default_nettype none

module shifting_array_list import sal_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [S_DATA_W-1:0]   i_s_axis_tdata,  // position, value, zero pad
    input  wire logic [OP_W-1:0]       i_s_axis_tuser,  // operation
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [M_DATA_W-1:0]        o_m_axis_tdata,  // read_value, count, zero pad
    output logic [STATUS_W-1:0]        o_m_axis_tuser   // status
);

    logic                     step;
    logic signed [WORD_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;

    // Handshake controller.
    sal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_step      (step)
    );

    // Word store and result register.
    sal_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_operation  (i_s_axis_tuser),
        .i_position   (i_s_axis_tdata[POS_W-1:0]),
        .i_value      (i_s_axis_tdata[POS_W+WORD_W-1:POS_W]),
        .o_read_value (read_value),
        .o_count      (count),
        .o_status     (o_m_axis_tuser)
    );

    // Result packing, lowest field first.
    assign o_m_axis_tdata = M_DATA_W'({count, read_value});

endmodule

`default_nettype wire

// File: src/sal_ctrl.sv
// Handshake controller for the shifting array list.
// Depends on sal_pkg; issues the step command to sal_datapath.
`default_nettype none

module sal_ctrl import sal_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output logic      o_step
);

    t_ctl_state r_state;
    t_ctl_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CTL_FREE;
        end else begin
            r_state <= n_state;
        end
    end

    // A new transaction is taken whenever the result register is free or drains now.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        n_state     = r_state;
        case (r_state)
            CTL_FREE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = CTL_HOLD;
                end
            end
            CTL_HOLD: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                if (i_out_ready && !i_in_valid) begin
                    n_state = CTL_FREE;
                end
            end
            default: begin
                n_state = CTL_FREE;
            end
        endcase
        o_step = i_in_valid && o_in_ready;
    end

endmodule

`default_nettype wire

// File: src/sal_datapath.sv
// Datapath of the shifting array list: a row of word cells, the fill count
// and the result register. Depends on sal_pkg; driven by sal_ctrl.
`default_nettype none

module sal_datapath import sal_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_step,
    input  wire logic [OP_W-1:0]          i_operation,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [WORD_W-1:0] i_value,
    output logic signed [WORD_W-1:0]      o_read_value,
    output logic [COUNT_W-1:0]            o_count,
    output logic [STATUS_W-1:0]           o_status
);

    logic signed [WORD_W-1:0] r_slots [CAPACITY];
    logic signed [WORD_W-1:0] n_slots [CAPACITY];
    logic [CNT_W-1:0]         r_fill;
    logic [CNT_W-1:0]         n_fill;

    logic signed [WORD_W-1:0] r_read_value;
    logic [CNT_W-1:0]         r_count;
    t_status                  r_status;

    t_op                      op;
    t_status                  n_status;
    logic signed [WORD_W-1:0] rd_word;
    logic                     full;
    logic                     empty;
    logic                     do_ins;
    logic                     do_popf;
    logic                     do_set;
    logic [CMP_W-1:0]         pos_w;
    logic [CMP_W-1:0]         cnt_w;
    logic [CMP_W-1:0]         ins_pos;

    assign op    = t_op'(i_operation);
    assign pos_w = CMP_W'(i_position);
    assign cnt_w = CMP_W'(r_fill);
    assign full  = (r_fill == CNT_W'(CAPACITY));
    assign empty = (r_fill == '0);

    // Operation decode, status and next fill count.
    always_comb begin
        n_fill   = r_fill;
        n_status = ST_DONE;
        rd_word  = '0;
        do_ins   = 1'b0;
        do_popf  = 1'b0;
        do_set   = 1'b0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    n_fill = r_fill + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    do_popf = 1'b1;
                    n_fill  = r_fill - CNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_fill = r_fill - CNT_W'(1);
                end
            end
            OP_GET: begin
                if (pos_w < CMP_W'(CAPACITY)) begin
                    rd_word = r_slots[IDX_W'(pos_w)];
                end
            end
            OP_SET: begin
                do_set = (pos_w < CMP_W'(CAPACITY));
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // Effective slot for a push or insert: the front for push front, the end for
    // push back and for an insert at or beyond the count, else the given position.
    always_comb begin
        if (op == OP_PUSH_FRONT) begin
            ins_pos = '0;
        end else if (op == OP_PUSH_BACK || pos_w >= cnt_w) begin
            ins_pos = cnt_w;
        end else begin
            ins_pos = pos_w;
        end
    end

    // Each cell picks its own word, the input value, its lower neighbor or its upper neighbor.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        always_comb begin
            n_slots[gi] = r_slots[gi];
            if (do_ins) begin
                if (CMP_W'(gi) == ins_pos) begin
                    n_slots[gi] = i_value;
                end else if (gi > 0 && CMP_W'(gi) > ins_pos && CMP_W'(gi) <= cnt_w) begin
                    n_slots[gi] = r_slots[(gi > 0) ? gi - 1 : 0];
                end
            end else if (do_popf) begin
                if (gi < CAPACITY - 1 && CMP_W'(gi + 1) < cnt_w) begin
                    n_slots[gi] = r_slots[(gi < CAPACITY - 1) ? gi + 1 : gi];
                end
            end else if (do_set && CMP_W'(gi) == pos_w) begin
                n_slots[gi] = i_value;
            end
        end
    end

    // Store and fill count update once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int k = 0; k < CAPACITY; k++) begin
                r_slots[k] <= '0;
            end
        end else if (i_step) begin
            r_fill  <= n_fill;
            r_slots <= n_slots;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_read_value <= rd_word;
            r_count      <= n_fill;
            r_status     <= n_status;
        end
    end

    assign o_read_value = r_read_value;
    assign o_count      = COUNT_W'(r_count);
    assign o_status     = r_status;

    // The fill count never passes the capacity.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // An add on a full store is refused and leaves the count at capacity.
    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK || op == OP_INSERT)
        |=> r_status == ST_FULL && r_count == CNT_W'(CAPACITY))
        else $error("add on full store not refused");

    // A pop on an empty store is refused and reports a zero count.
    a_empty_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && empty && (op == OP_POP_FRONT || op == OP_POP_BACK)
        |=> r_status == ST_EMPTY && r_count == '0)
        else $error("pop on empty store not refused");

    // Without a transaction the fill count holds.
    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_fill))
        else $error("fill count changed without a transaction");

endmodule

`default_nettype wire
